// ===== hdl/fsa_pkg.sv =====
// Shared types and constants for the fit strategy allocator.
// No dependencies; imported by fsa_cell and fit_strategy_allocator.
package fsa_pkg;

  // Default sizing
  localparam int MAX_SEGMENTS_DEF   = 64;
  localparam int POOL_ADDR_BITS_DEF = 20;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NOFIT    = 3'd1;
  localparam logic [2:0] STAT_ZERO     = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;

  // Fit rules
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_FIT_RULE   = 1'b0;
  localparam logic CFG_POOL_BYTES = 1'b1;

  // Table update broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_MARK,
    OP_SPLIT,
    OP_FREE,
    OP_FREE_NEXT,
    OP_FREE_PREV,
    OP_FREE_BOTH
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

endpackage

// ===== hdl/fit_strategy_allocator.sv =====
// Top level of the fit strategy allocator: controller and row of table cells.
// Depends on fsa_pkg and fsa_cell.
//
// The pool is an address-ordered segment table held one entry per cell in a
// row of MAX_SEGMENTS cells. Each request is taken when in_ready is high,
// then a search token walks the row one cell per clock. The walk counter runs
// in S_SCAN until the token has passed the last cell; in S_APPLY the result is
// loaded once the output register is free, and the controller returns to
// S_IDLE, where the next item can be taken. Splits and merges move the
// entries together, in one update of the row at the end of the walk. One item
// is in work at a time; a finished result waits in the output register and
// the next item may be taken meanwhile, but that item holds at the end of its
// walk until the waiting result is accepted. Writing pool_bytes resets the
// table to one free segment at once and needs no clearing pass.
module fit_strategy_allocator import fsa_pkg::*; #(
  parameter int MAX_SEGMENTS   = MAX_SEGMENTS_DEF,
  parameter int POOL_ADDR_BITS = POOL_ADDR_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic [POOL_ADDR_BITS:0]   request_size,
  input  logic [POOL_ADDR_BITS-1:0] block_offset,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [POOL_ADDR_BITS-1:0] granted_offset,
  output logic [POOL_ADDR_BITS:0]   bytes_allocated,
  output logic [POOL_ADDR_BITS:0]   bytes_free,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [POOL_ADDR_BITS:0]   cfg_data
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = POOL_ADDR_BITS;
  localparam int LW = POOL_ADDR_BITS + 1;
  localparam logic [LW-1:0] POOL_MAX = LW'(1) << AW;
  localparam logic [IW-1:0] LAST_CNT = IW'(MAX_SEGMENTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_SEGMENTS);

  // Control and registers
  state_t        state, state_next;
  logic [IW-1:0] cnt;
  logic          cmd_r;
  logic [LW-1:0] req_r;
  logic [AW-1:0] addr_r;
  logic [1:0]    rule;
  logic [LW-1:0] pool;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] rover, rover_next;
  logic [LW-1:0] used_total, used_next;
  logic          go;
  logic [2:0]    stat_next;
  logic [AW-1:0] grant_next;
  op_t           apply_op, cell_op;
  logic [LW-1:0] pool_wr, init_len;

  // Row wiring
  logic [AW-1:0] e_start [MAX_SEGMENTS];
  logic [LW-1:0] e_len   [MAX_SEGMENTS];
  logic          e_used  [MAX_SEGMENTS];

  logic          t_f_found [MAX_SEGMENTS+1];
  logic [IW-1:0] t_f_idx   [MAX_SEGMENTS+1];
  logic [LW-1:0] t_f_len   [MAX_SEGMENTS+1];
  logic [AW-1:0] t_f_start [MAX_SEGMENTS+1];
  logic          t_g_found [MAX_SEGMENTS+1];
  logic [IW-1:0] t_g_idx   [MAX_SEGMENTS+1];
  logic [LW-1:0] t_g_len   [MAX_SEGMENTS+1];
  logic [AW-1:0] t_g_start [MAX_SEGMENTS+1];
  logic          t_l_used  [MAX_SEGMENTS+1];
  logic [LW-1:0] t_l_len   [MAX_SEGMENTS+1];
  logic          t_hit     [MAX_SEGMENTS+1];
  logic          t_pv_free [MAX_SEGMENTS+1];
  logic [LW-1:0] t_pv_len  [MAX_SEGMENTS+1];
  logic          t_nx_free [MAX_SEGMENTS+1];
  logic [LW-1:0] t_nx_len  [MAX_SEGMENTS+1];

  // Chosen segment from the token at the end of the row
  logic          use_g;
  logic          found;
  logic [IW-1:0] p_idx;
  logic [LW-1:0] p_len;
  logic [AW-1:0] p_start;
  logic [CW-1:0] pk;
  logic [CW-1:0] r;

  // Empty token enters the row at cell zero
  assign t_f_found[0] = 1'b0;
  assign t_f_idx[0]   = '0;
  assign t_f_len[0]   = '0;
  assign t_f_start[0] = '0;
  assign t_g_found[0] = 1'b0;
  assign t_g_idx[0]   = '0;
  assign t_g_len[0]   = '0;
  assign t_g_start[0] = '0;
  assign t_l_used[0]  = 1'b1;
  assign t_l_len[0]   = '0;
  assign t_hit[0]     = 1'b0;
  assign t_pv_free[0] = 1'b0;
  assign t_pv_len[0]  = '0;
  assign t_nx_free[0] = 1'b0;
  assign t_nx_len[0]  = '0;

  // Row of table cells
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    logic [AW-1:0] ls, r1s, r2s;
    logic [LW-1:0] ll, r1l, r2l;
    logic          lu, r1u, r2u;

    if (k > 0) begin : g_l
      assign ls = e_start[k-1];
      assign ll = e_len[k-1];
      assign lu = e_used[k-1];
    end else begin : g_l0
      assign ls = '0;
      assign ll = '0;
      assign lu = 1'b0;
    end
    if (k + 1 < MAX_SEGMENTS) begin : g_r1
      assign r1s = e_start[k+1];
      assign r1l = e_len[k+1];
      assign r1u = e_used[k+1];
    end else begin : g_r10
      assign r1s = '0;
      assign r1l = '0;
      assign r1u = 1'b0;
    end
    if (k + 2 < MAX_SEGMENTS) begin : g_r2
      assign r2s = e_start[k+2];
      assign r2l = e_len[k+2];
      assign r2u = e_used[k+2];
    end else begin : g_r20
      assign r2s = '0;
      assign r2l = '0;
      assign r2u = 1'b0;
    end

    fsa_cell #(
      .MAX_SEGMENTS  (MAX_SEGMENTS),
      .POOL_ADDR_BITS(POOL_ADDR_BITS),
      .IDX           (k)
    ) u_cell (
      .clk         (clk),
      .op          (cell_op),
      .pick        (p_idx),
      .req         (req_r),
      .p_start     (p_start),
      .p_len       (p_len),
      .n_len       (t_nx_len[MAX_SEGMENTS]),
      .init_len    (init_len),
      .cmd         (cmd_r),
      .rule        (rule),
      .addr        (addr_r),
      .rover       (rover),
      .count       (count),
      .l_start     (ls),
      .l_len       (ll),
      .l_used      (lu),
      .r1_start    (r1s),
      .r1_len      (r1l),
      .r1_used     (r1u),
      .r2_start    (r2s),
      .r2_len      (r2l),
      .r2_used     (r2u),
      .seg_start   (e_start[k]),
      .seg_length  (e_len[k]),
      .seg_used    (e_used[k]),
      .ti_f_found  (t_f_found[k]),
      .ti_f_idx    (t_f_idx[k]),
      .ti_f_len    (t_f_len[k]),
      .ti_f_start  (t_f_start[k]),
      .ti_g_found  (t_g_found[k]),
      .ti_g_idx    (t_g_idx[k]),
      .ti_g_len    (t_g_len[k]),
      .ti_g_start  (t_g_start[k]),
      .ti_last_used(t_l_used[k]),
      .ti_last_len (t_l_len[k]),
      .ti_hit      (t_hit[k]),
      .ti_pv_free  (t_pv_free[k]),
      .ti_pv_len   (t_pv_len[k]),
      .ti_nx_free  (t_nx_free[k]),
      .ti_nx_len   (t_nx_len[k]),
      .to_f_found  (t_f_found[k+1]),
      .to_f_idx    (t_f_idx[k+1]),
      .to_f_len    (t_f_len[k+1]),
      .to_f_start  (t_f_start[k+1]),
      .to_g_found  (t_g_found[k+1]),
      .to_g_idx    (t_g_idx[k+1]),
      .to_g_len    (t_g_len[k+1]),
      .to_g_start  (t_g_start[k+1]),
      .to_last_used(t_l_used[k+1]),
      .to_last_len (t_l_len[k+1]),
      .to_hit      (t_hit[k+1]),
      .to_pv_free  (t_pv_free[k+1]),
      .to_pv_len   (t_pv_len[k+1]),
      .to_nx_free  (t_nx_free[k+1]),
      .to_nx_len   (t_nx_len[k+1])
    );
  end

  assign in_ready = (state == S_IDLE);
  assign go       = (state == S_APPLY) && (!out_valid || out_ready);

  // Clamp a written pool size into range
  always_comb begin
    pool_wr = cfg_data;
    if (pool_wr == '0) pool_wr = LW'(1);
    if (pool_wr > POOL_MAX) pool_wr = POOL_MAX;
  end

  // Select the update driven into the row
  always_comb begin
    init_len = pool_wr;
    if (rst) begin
      cell_op  = OP_INIT;
      init_len = POOL_MAX;
    end else if (cfg_we && cfg_index == CFG_POOL_BYTES) begin
      cell_op = OP_INIT;
    end else if (go) begin
      cell_op = apply_op;
    end else begin
      cell_op = OP_NONE;
    end
  end

  // Pick the segment named by the finished token
  always_comb begin
    use_g = (rule == FIT_NEXT) && t_g_found[MAX_SEGMENTS] && (cmd_r == CMD_ALLOC);
    found = t_f_found[MAX_SEGMENTS];
    if (use_g) begin
      p_idx   = t_g_idx[MAX_SEGMENTS];
      p_len   = t_g_len[MAX_SEGMENTS];
      p_start = t_g_start[MAX_SEGMENTS];
    end else begin
      p_idx   = t_f_idx[MAX_SEGMENTS];
      p_len   = t_f_len[MAX_SEGMENTS];
      p_start = t_f_start[MAX_SEGMENTS];
    end
    pk = CW'(p_idx);
  end

  // Decide the outcome of the item and the new bookkeeping
  always_comb begin
    apply_op   = OP_NONE;
    stat_next  = STAT_OK;
    grant_next = '0;
    count_next = count;
    rover_next = rover;
    used_next  = used_total;
    r          = CW'(rover);
    if (cmd_r == CMD_ALLOC) begin
      if (req_r == '0) begin
        stat_next = STAT_ZERO;
      end else if (!found) begin
        stat_next = STAT_NOFIT;
      end else if (p_len > req_r && count == FULL_CNT) begin
        stat_next = STAT_FULL;
      end else begin
        if (p_len > req_r) begin
          apply_op   = OP_SPLIT;
          count_next = count + CW'(1);
        end else begin
          apply_op = OP_MARK;
        end
        used_next  = used_total + req_r;
        grant_next = p_start;
        r = pk + CW'(1);
        if (r >= count_next) r = '0;
        rover_next = r[IW-1:0];
      end
    end else begin
      if (!found) begin
        stat_next = STAT_NOTFOUND;
      end else begin
        used_next = used_total - p_len;
        // merge with the following free segment
        if (t_nx_free[MAX_SEGMENTS]) begin
          if (r > pk + CW'(1)) begin
            r = r - CW'(1);
          end else if (r == pk + CW'(1)) begin
            r = pk;
          end
        end
        // merge into the preceding free segment
        if (t_pv_free[MAX_SEGMENTS]) begin
          if (r > pk) begin
            r = r - CW'(1);
          end else if (r == pk) begin
            r = pk - CW'(1);
          end
        end
        if (t_nx_free[MAX_SEGMENTS] && t_pv_free[MAX_SEGMENTS]) begin
          apply_op   = OP_FREE_BOTH;
          count_next = count - CW'(2);
        end else if (t_nx_free[MAX_SEGMENTS]) begin
          apply_op   = OP_FREE_NEXT;
          count_next = count - CW'(1);
        end else if (t_pv_free[MAX_SEGMENTS]) begin
          apply_op   = OP_FREE_PREV;
          count_next = count - CW'(1);
        end else begin
          apply_op = OP_FREE;
        end
        if (r >= count_next) r = '0;
        rover_next = r[IW-1:0];
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SCAN;
      S_SCAN:  if (cnt == LAST_CNT) state_next = S_APPLY;
      S_APPLY: if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State register and walk counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        cnt <= cnt + IW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= cmd;
      req_r  <= request_size;
      addr_r <= block_offset;
    end
  end

  // Hold configuration and table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      rule       <= FIT_FIRST;
      pool       <= POOL_MAX;
      count      <= CW'(1);
      rover      <= '0;
      used_total <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIT_RULE) begin
        rule <= cfg_data[1:0];
      end else begin
        pool       <= pool_wr;
        count      <= CW'(1);
        rover      <= '0;
        used_total <= '0;
      end
    end else if (go) begin
      count      <= count_next;
      rover      <= rover_next;
      used_total <= used_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status          <= stat_next;
      granted_offset  <= grant_next;
      bytes_allocated <= used_next;
      bytes_free      <= pool - used_next;
    end
  end

endmodule

// ===== hdl/fsa_cell.sv =====
// One segment table entry plus one stage of the search chain.
// Depends on fsa_pkg; instantiated in a row by fit_strategy_allocator.
module fsa_cell import fsa_pkg::*; #(
  parameter int MAX_SEGMENTS   = MAX_SEGMENTS_DEF,
  parameter int POOL_ADDR_BITS = POOL_ADDR_BITS_DEF,
  parameter int IDX            = 0
) (
  input  logic                                clk,
  // update broadcast
  input  op_t                                 op,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]     pick,
  input  logic [POOL_ADDR_BITS:0]             req,
  input  logic [POOL_ADDR_BITS-1:0]           p_start,
  input  logic [POOL_ADDR_BITS:0]             p_len,
  input  logic [POOL_ADDR_BITS:0]             n_len,
  input  logic [POOL_ADDR_BITS:0]             init_len,
  // search broadcast
  input  logic                                cmd,
  input  logic [1:0]                          rule,
  input  logic [POOL_ADDR_BITS-1:0]           addr,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]     rover,
  input  logic [$clog2(MAX_SEGMENTS+1)-1:0]   count,
  // neighbor entries
  input  logic [POOL_ADDR_BITS-1:0]           l_start,
  input  logic [POOL_ADDR_BITS:0]             l_len,
  input  logic                                l_used,
  input  logic [POOL_ADDR_BITS-1:0]           r1_start,
  input  logic [POOL_ADDR_BITS:0]             r1_len,
  input  logic                                r1_used,
  input  logic [POOL_ADDR_BITS-1:0]           r2_start,
  input  logic [POOL_ADDR_BITS:0]             r2_len,
  input  logic                                r2_used,
  output logic [POOL_ADDR_BITS-1:0]           seg_start,
  output logic [POOL_ADDR_BITS:0]             seg_length,
  output logic                                seg_used,
  // search token in
  input  logic                                ti_f_found,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]     ti_f_idx,
  input  logic [POOL_ADDR_BITS:0]             ti_f_len,
  input  logic [POOL_ADDR_BITS-1:0]           ti_f_start,
  input  logic                                ti_g_found,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]     ti_g_idx,
  input  logic [POOL_ADDR_BITS:0]             ti_g_len,
  input  logic [POOL_ADDR_BITS-1:0]           ti_g_start,
  input  logic                                ti_last_used,
  input  logic [POOL_ADDR_BITS:0]             ti_last_len,
  input  logic                                ti_hit,
  input  logic                                ti_pv_free,
  input  logic [POOL_ADDR_BITS:0]             ti_pv_len,
  input  logic                                ti_nx_free,
  input  logic [POOL_ADDR_BITS:0]             ti_nx_len,
  // search token out
  output logic                                to_f_found,
  output logic [$clog2(MAX_SEGMENTS)-1:0]     to_f_idx,
  output logic [POOL_ADDR_BITS:0]             to_f_len,
  output logic [POOL_ADDR_BITS-1:0]           to_f_start,
  output logic                                to_g_found,
  output logic [$clog2(MAX_SEGMENTS)-1:0]     to_g_idx,
  output logic [POOL_ADDR_BITS:0]             to_g_len,
  output logic [POOL_ADDR_BITS-1:0]           to_g_start,
  output logic                                to_last_used,
  output logic [POOL_ADDR_BITS:0]             to_last_len,
  output logic                                to_hit,
  output logic                                to_pv_free,
  output logic [POOL_ADDR_BITS:0]             to_pv_len,
  output logic                                to_nx_free,
  output logic [POOL_ADDR_BITS:0]             to_nx_len
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MY = CW'(IDX);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [CW-1:0] pk;
  logic          valid;
  logic          cand;
  logic          take_f;

  assign pk    = CW'(pick);
  assign valid = MY < count;

  // Candidate test and pick rule for this entry
  always_comb begin
    if (cmd == CMD_FREE) begin
      cand = valid && seg_used && (seg_start == addr);
    end else begin
      cand = valid && !seg_used && (seg_length >= req);
    end
    if (!ti_f_found) begin
      take_f = cand;
    end else if (cmd == CMD_ALLOC && rule == FIT_BEST) begin
      take_f = cand && (seg_length < ti_f_len);
    end else if (cmd == CMD_ALLOC && rule == FIT_WORST) begin
      take_f = cand && (seg_length > ti_f_len);
    end else begin
      take_f = 1'b0;
    end
  end

  // Advance the search token one cell
  always_ff @(posedge clk) begin
    to_last_used <= seg_used;
    to_last_len  <= seg_length;
    to_hit       <= take_f;
    if (take_f) begin
      to_f_found <= 1'b1;
      to_f_idx   <= MY_IDX;
      to_f_len   <= seg_length;
      to_f_start <= seg_start;
      to_pv_free <= (IDX != 0) && !ti_last_used;
      to_pv_len  <= ti_last_len;
    end else begin
      to_f_found <= ti_f_found;
      to_f_idx   <= ti_f_idx;
      to_f_len   <= ti_f_len;
      to_f_start <= ti_f_start;
      to_pv_free <= ti_pv_free;
      to_pv_len  <= ti_pv_len;
    end
    if (ti_hit) begin
      to_nx_free <= valid && !seg_used;
      to_nx_len  <= seg_length;
    end else begin
      to_nx_free <= ti_nx_free;
      to_nx_len  <= ti_nx_len;
    end
    if (!ti_g_found && cand && cmd == CMD_ALLOC && MY_IDX >= rover) begin
      to_g_found <= 1'b1;
      to_g_idx   <= MY_IDX;
      to_g_len   <= seg_length;
      to_g_start <= seg_start;
    end else begin
      to_g_found <= ti_g_found;
      to_g_idx   <= ti_g_idx;
      to_g_len   <= ti_g_len;
      to_g_start <= ti_g_start;
    end
  end

  // Update the entry: init, mark, split, free or merge, shifting with neighbors
  always_ff @(posedge clk) begin
    unique case (op)
      OP_INIT: begin
        seg_used <= 1'b0;
        if (IDX == 0) begin
          seg_start  <= '0;
          seg_length <= init_len;
        end
      end
      OP_MARK: begin
        if (MY == pk) seg_used <= 1'b1;
      end
      OP_SPLIT: begin
        if (MY == pk) begin
          seg_length <= req;
          seg_used   <= 1'b1;
        end else if (MY == pk + CW'(1)) begin
          seg_start  <= p_start + req[POOL_ADDR_BITS-1:0];
          seg_length <= p_len - req;
          seg_used   <= 1'b0;
        end else if (MY > pk + CW'(1)) begin
          seg_start  <= l_start;
          seg_length <= l_len;
          seg_used   <= l_used;
        end
      end
      OP_FREE: begin
        if (MY == pk) seg_used <= 1'b0;
      end
      OP_FREE_NEXT: begin
        if (MY == pk) begin
          seg_used   <= 1'b0;
          seg_length <= p_len + n_len;
        end else if (MY > pk) begin
          seg_start  <= r1_start;
          seg_length <= r1_len;
          seg_used   <= r1_used;
        end
      end
      OP_FREE_PREV: begin
        if (MY + CW'(1) == pk) begin
          seg_length <= seg_length + p_len;
        end else if (MY >= pk) begin
          seg_start  <= r1_start;
          seg_length <= r1_len;
          seg_used   <= r1_used;
        end
      end
      OP_FREE_BOTH: begin
        if (MY + CW'(1) == pk) begin
          seg_length <= seg_length + p_len + n_len;
        end else if (MY >= pk) begin
          seg_start  <= r2_start;
          seg_length <= r2_len;
          seg_used   <= r2_used;
        end
      end
      default: begin
        seg_used <= seg_used;
      end
    endcase
  end

endmodule

// ===== bench/fit_strategy_allocator_test.sv =====
// Self-checking bench for fit_strategy_allocator: random and directed
// alloc/free items checked against a segment-table predictor.
// Depends on fsa_pkg and the fit_strategy_allocator RTL.
`timescale 1ns / 1ps

module fit_strategy_allocator_test;
  import fsa_pkg::*;

  localparam int SEGS  = MAX_SEGMENTS_DEF;
  localparam int ABITS = POOL_ADDR_BITS_DEF;
  localparam int LW    = ABITS + 1;
  localparam int LATENCY = SEGS + 8;

  typedef struct packed {
    logic             cmd;
    logic [ABITS:0]   size;
    logic [ABITS-1:0] offset;
  } request_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ABITS-1:0] granted;
    logic [ABITS:0]   used;
    logic [ABITS:0]   avail;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [ABITS:0] request_size = '0;
  logic [ABITS-1:0] block_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [ABITS-1:0] granted_offset;
  logic [ABITS:0] bytes_allocated;
  logic [ABITS:0] bytes_free;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [ABITS:0] cfg_data = '0;

  fit_strategy_allocator uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: mirror of the segment table
  logic [1:0]     rule_m;
  logic [ABITS:0] pool_m;
  logic [ABITS:0] start_m [SEGS];
  logic [ABITS:0] len_m [SEGS];
  logic           busy_m [SEGS];
  int             count_m, rover_m;
  logic [ABITS:0] used_m;

  request_t pending_q [$];
  answer_t  answers_q [$];
  int errors = 0;
  bit quiet_src = 1'b1, quiet_snk = 1'b1;
  bit hold_sink = 1'b0;
  bit pause_src = 1'b0;
  bit in_took = 1'b0;

  function automatic void table_reset();
    for (int k = 0; k < SEGS; k++) begin
      start_m[k] = '0; len_m[k] = '0; busy_m[k] = 1'b0;
    end
    len_m[0] = pool_m;
    count_m = 1; rover_m = 0; used_m = '0;
  endfunction

  function automatic void open_slot(int pos);
    for (int k = count_m; k > pos; k--) begin
      start_m[k] = start_m[k-1]; len_m[k] = len_m[k-1]; busy_m[k] = busy_m[k-1];
    end
    count_m++;
    if (rover_m >= pos) rover_m++;
  endfunction

  function automatic void drop_slot(int pos);
    for (int k = pos; k + 1 < count_m; k++) begin
      start_m[k] = start_m[k+1]; len_m[k] = len_m[k+1]; busy_m[k] = busy_m[k+1];
    end
    count_m--;
    if (rover_m > pos) rover_m--;
    else if (rover_m == pos) rover_m = pos - 1;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int pick, pos;
    bit found;
    a = '0;
    pick = 0; pos = 0; found = 1'b0;
    if (r.cmd == CMD_ALLOC) begin
      if (r.size == 0) a.status = STAT_ZERO;
      else begin
        if (rule_m == FIT_NEXT) begin
          if (rover_m >= count_m) rover_m = 0;
          pos = rover_m;
          for (int k = 0; k < count_m && !found; k++) begin
            if (!busy_m[pos] && len_m[pos] >= r.size) begin
              pick = pos; found = 1'b1;
            end else begin
              pos++;
              if (pos >= count_m) pos = 0;
            end
          end
        end else begin
          for (int k = 0; k < count_m; k++) begin
            if (!busy_m[k] && len_m[k] >= r.size) begin
              if (!found) begin
                pick = k; found = 1'b1;
              end else if (rule_m == FIT_BEST && len_m[k] < len_m[pick]) pick = k;
              else if (rule_m == FIT_WORST && len_m[k] > len_m[pick]) pick = k;
            end
            if (rule_m == FIT_FIRST && found) break;
          end
        end
        if (!found) a.status = STAT_NOFIT;
        else if (len_m[pick] > r.size && count_m >= SEGS) a.status = STAT_FULL;
        else begin
          if (len_m[pick] > r.size) begin
            open_slot(pick);
            len_m[pick] = r.size;
            start_m[pick+1] = start_m[pick] + r.size;
            len_m[pick+1] = len_m[pick+1] - r.size;
          end
          busy_m[pick] = 1'b1;
          used_m = used_m + r.size;
          a.status = STAT_OK;
          a.granted = start_m[pick][ABITS-1:0];
          rover_m = pick + 1;
          if (rover_m >= count_m) rover_m = 0;
        end
      end
    end else begin
      for (int k = 0; k < count_m && !found; k++)
        if (busy_m[k] && start_m[k] == {1'b0, r.offset}) begin
          pos = k; found = 1'b1;
        end
      if (!found) a.status = STAT_NOTFOUND;
      else begin
        busy_m[pos] = 1'b0;
        used_m = used_m - len_m[pos];
        if (pos + 1 < count_m && !busy_m[pos+1]) begin
          len_m[pos] = len_m[pos] + len_m[pos+1];
          drop_slot(pos + 1);
        end
        if (pos > 0 && !busy_m[pos-1]) begin
          len_m[pos-1] = len_m[pos-1] + len_m[pos];
          drop_slot(pos);
        end
        if (rover_m >= count_m) rover_m = 0;
        a.status = STAT_OK;
      end
    end
    a.used = used_m;
    a.avail = pool_m - used_m;
    return a;
  endfunction

  // Record each accepted item and predict its result
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      answers_q.push_back(predict_answer(pending_q.pop_front()));
      in_took = 1'b1;
    end else begin
      in_took = 1'b0;
    end
  end

  // Driver: hold the offered item until taken, then present the next one
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (pending_q.size() > 0 && !pause_src &&
            (quiet_src || $urandom_range(99) >= 22)) begin
          in_valid <= 1'b1;
          cmd <= pending_q[0].cmd;
          request_size <= pending_q[0].size;
          block_offset <= pending_q[0].offset;
        end else in_valid <= 1'b0;
      end
      out_ready <= !hold_sink && (quiet_snk || $urandom_range(99) >= 22);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && out_valid && out_ready) begin
      if (answers_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status);
        errors++;
      end else begin
        exp_a = answers_q.pop_front();
        if (status !== exp_a.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_a.status, status);
          errors++;
        end
        if (granted_offset !== exp_a.granted) begin
          $display("%0t: granted_offset exp %0h got %0h", $time, exp_a.granted,
                   granted_offset);
          errors++;
        end
        if (bytes_allocated !== exp_a.used) begin
          $display("%0t: bytes_allocated exp %0d got %0d", $time, exp_a.used,
                   bytes_allocated);
          errors++;
        end
        if (bytes_free !== exp_a.avail) begin
          $display("%0t: bytes_free exp %0d got %0d", $time, exp_a.avail, bytes_free);
          errors++;
        end
      end
    end
  end

  // Wait until everything queued has come back, then settle
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || answers_q.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ABITS:0] val);
    logic [ABITS:0] v;
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIT_RULE) rule_m = val[1:0];
    else begin
      v = val;
      if (v == '0) v = LW'(1);
      if (v > LW'(1 << ABITS)) v = LW'(1 << ABITS);
      pool_m = v;
      table_reset();
    end
  endtask

  function automatic void add_item(logic c, logic [ABITS:0] s, logic [ABITS-1:0] o);
    request_t r;
    r.cmd = c; r.size = s; r.offset = o;
    pending_q.push_back(r);
  endfunction

  // Random phase: allocate mostly, free offsets likely to be live
  task automatic random_phase(int n, int max_sz);
    logic [ABITS-1:0] live [$];
    logic [ABITS-1:0] o;
    logic [ABITS-1:0] off;
    int pos;
    logic [ABITS:0] sz;
    o = '0;
    for (int i = 0; i < n; i++) begin
      pos = $urandom_range(99);
      if (pos < 50) begin
        sz = LW'($urandom_range(max_sz, 1));
        if ($urandom_range(49) == 0) sz = LW'($urandom);
        add_item(CMD_ALLOC, sz, ABITS'($urandom));
        live.push_back(o);
        o = o + sz[ABITS-1:0];
      end else if (pos < 92) begin
        if (live.size() > 0 && $urandom_range(1) == 0)
          off = live[$urandom_range(live.size() - 1)];
        else off = ABITS'($urandom_range(max_sz * 16));
        add_item(CMD_FREE, LW'($urandom), off);
      end else add_item(1'($urandom), LW'($urandom), ABITS'($urandom));
    end
  endtask

  // Stimulus
  initial begin
    rule_m = FIT_FIRST; pool_m = LW'(1 << ABITS); table_reset();
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: extremes of the default pool
    add_item(CMD_ALLOC, '0, '1);
    add_item(CMD_ALLOC, LW'(1 << ABITS), '0);
    add_item(CMD_FREE, '0, '0);
    add_item(CMD_ALLOC, LW'(1 << ABITS), '0);
    add_item(CMD_ALLOC, LW'(1), '0);
    add_item(CMD_FREE, '1, '0);
    add_item(CMD_FREE, '0, '0);
    add_item(CMD_ALLOC, '1, '1);
    add_item(CMD_ALLOC, LW'(100), '0);
    add_item(CMD_ALLOC, LW'(200), '0);
    add_item(CMD_ALLOC, LW'(300), '0);
    add_item(CMD_FREE, '0, ABITS'(100));
    add_item(CMD_FREE, '0, '0);
    add_item(CMD_FREE, '0, ABITS'(300));
    add_item(CMD_FREE, '0, ABITS'(100));
    drain();

    // directed: pool size saturation and zero
    write_reg(CFG_POOL_BYTES, '0);
    add_item(CMD_ALLOC, LW'(2), '0);
    add_item(CMD_ALLOC, LW'(1), '0);
    drain();
    write_reg(CFG_POOL_BYTES, '1);
    add_item(CMD_ALLOC, LW'(1 << ABITS), '0);
    drain();

    // table full: fill with small splits in a tiny-grain pool
    write_reg(CFG_FIT_RULE, LW'(FIT_FIRST));
    write_reg(CFG_POOL_BYTES, LW'(1000));
    for (int i = 0; i < SEGS + 2; i++) add_item(CMD_ALLOC, LW'(1), '0);
    add_item(CMD_ALLOC, LW'(1000 - SEGS + 1), '0);
    drain();

    // random phases over every rule and several pool sizes
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FIT_RULE, LW'(ph % 4));
      write_reg(CFG_POOL_BYTES, LW'((ph == 7) ? (1 << ABITS) : (ph < 4 ? 4096 : 256)));
      quiet_src = (ph == 2); quiet_snk = (ph == 2);
      if (ph == 3) begin
        // receiver holds off while the sender keeps offering items
        hold_sink = 1'b1;
        random_phase(160, 64);
        fork
          begin
            repeat (600) @(posedge clk);
            hold_sink = 1'b0;
          end
        join_none
      end else random_phase(160, ph < 4 ? 64 : 16);
      drain();
    end

    // sender pauses until every result has come back
    random_phase(20, 32);
    repeat (300) @(posedge clk);
    pause_src = 1'b1;
    while (in_valid || answers_q.size() > 0) @(posedge clk);
    pause_src = 1'b0;
    drain();

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Timeout guard
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== fit_strategy_allocator.f =====
hdl/fsa_pkg.sv
hdl/fsa_cell.sv
hdl/fit_strategy_allocator.sv
bench/fit_strategy_allocator_test.sv
